### src/spt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted position table.
// Used by spt_cell and sorted_position_table_unit; depends on nothing else.
package spt_pkg;

  // Default sizing, handed to the top level as parameter defaults.
  localparam int DefTableDepth   = 64;
  localparam int DefPositionBits = 16;
  localparam int DefHandleBits   = 16;

  localparam int FuncW   = 3;
  localparam int StatusW = 3;

  // Request operation codes.
  typedef enum logic [FuncW-1:0] {
    FN_INSERT   = 3'd0,
    FN_ERASE    = 3'd1,
    FN_RELEASE  = 3'd2,
    FN_GET      = 3'd3,
    FN_SHIFT_UP = 3'd4,
    FN_SHIFT_DN = 3'd5
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             cmp;    // compare every cell against the new key
    logic             exec;   // apply the registered request
    logic [FuncW-1:0] func;   // operation of the registered request
    logic             found;  // the key matched at the lower bound
    logic             full;   // every slot is occupied
  } cell_cmd_t;

endpackage

### src/spt_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted position table: holds a position and a handle.
// Depends on spt_pkg; instantiated in a chain by sorted_position_table_unit.
module spt_cell import spt_pkg::*; #(
  parameter int POSITION_BITS = DefPositionBits,
  parameter int HANDLE_BITS   = DefHandleBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_cmd_t                cmd_i,
  input  logic [POSITION_BITS-1:0] key_i,
  input  logic [POSITION_BITS-1:0] new_pos_i,
  input  logic [HANDLE_BITS-1:0]   new_handle_i,
  input  logic                     valid_i,
  input  logic                     left_after_i,
  input  logic [POSITION_BITS-1:0] left_pos_i,
  input  logic [HANDLE_BITS-1:0]   left_handle_i,
  input  logic [POSITION_BITS-1:0] right_pos_i,
  input  logic [HANDLE_BITS-1:0]   right_handle_i,
  output logic                     after_o,
  output logic                     hit_o,
  output logic                     at_max_o,
  output logic                     at_zero_o,
  output logic [POSITION_BITS-1:0] pos_o,
  output logic [HANDLE_BITS-1:0]   handle_o
);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [HANDLE_BITS-1:0]   handle_q, handle_d;
  logic                     after_q, eq_q;

  // The compare flags are taken when a request is transferred in. An empty
  // slot counts as lying at or after any key, which keeps the flags monotone
  // along the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_q <= 1'b0;
      eq_q    <= 1'b0;
    end else if (cmd_i.cmp) begin
      after_q <= !valid_i || (pos_q >= key_i);
      eq_q    <= (pos_q == key_i);
    end
  end

  // The lower bound is the first slot that is after while its left neighbour is not.
  assign hit_o     = after_q && !left_after_i && valid_i && eq_q;
  assign at_max_o  = after_q && valid_i && (pos_q == {POSITION_BITS{1'b1}});
  assign at_zero_o = after_q && valid_i && (pos_q == '0);

  // Per-slot update for the registered request.
  always_comb begin
    pos_d    = pos_q;
    handle_d = handle_q;
    if (cmd_i.exec) begin
      unique case (cmd_i.func)
        FN_INSERT: begin
          if (!cmd_i.found && !cmd_i.full) begin
            if (left_after_i) begin
              pos_d    = left_pos_i;
              handle_d = left_handle_i;
            end else if (after_q) begin
              pos_d    = new_pos_i;
              handle_d = new_handle_i;
            end
          end
        end
        FN_ERASE: begin
          if (cmd_i.found && after_q) begin
            pos_d    = right_pos_i;
            handle_d = right_handle_i;
          end
        end
        FN_RELEASE: begin
          if (hit_o) begin
            handle_d = '0;
          end
        end
        FN_SHIFT_UP: begin
          if (after_q && valid_i && !at_max_o) begin
            pos_d = pos_q + POSITION_BITS'(1);
          end
        end
        FN_SHIFT_DN: begin
          if (after_q && valid_i && !at_zero_o) begin
            pos_d = pos_q - POSITION_BITS'(1);
          end
        end
        default: begin
          pos_d    = pos_q;
          handle_d = handle_q;
        end
      endcase
    end
  end

  // Slot contents are undefined until written and carry no reset.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    handle_q <= handle_d;
  end

  assign after_o  = after_q;
  assign pos_o    = pos_q;
  assign handle_o = handle_q;

endmodule

### src/sorted_position_table_unit.sv
`timescale 1ns / 1ps
// Sorted position table. In the cycle of the input transfer each cell of the
// chain compares its stored position with the requested one; the request is
// then held in the execute state until the result register is free, when the
// controller combines the per-cell flags into the lower-bound match and every
// cell shifts, loads or adjusts its entry at once, while the result is
// registered for output. A new request is taken only once the previous one
// has been applied, so the block never works on two requests at a time.
// The table holds TABLE_DEPTH entries and needs no clearing after reset.
// Depends on spt_pkg and spt_cell.
module sorted_position_table_unit import spt_pkg::*; #(
  parameter int TABLE_DEPTH   = DefTableDepth,
  parameter int POSITION_BITS = DefPositionBits,
  parameter int HANDLE_BITS   = DefHandleBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FuncW-1:0]         func_i,
  input  logic [POSITION_BITS-1:0] position_i,
  input  logic [HANDLE_BITS-1:0]   handle_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [HANDLE_BITS-1:0]   handle_out_o,
  output logic [StatusW-1:0]       status_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                   state_q;
  logic [CntW-1:0]          count_q;
  logic [FuncW-1:0]         func_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [HANDLE_BITS-1:0]   hin_q;
  logic                     out_valid_q;
  logic [HANDLE_BITS-1:0]   handle_out_q;
  logic [StatusW-1:0]       status_q;

  logic                     in_xfer, fire;
  cell_cmd_t                cmd;

  logic [POSITION_BITS-1:0] cell_pos    [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]   cell_handle [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   cell_after, cell_hit, cell_max, cell_zero, cell_valid;

  logic                     found, sat_up, sat_dn;
  logic [HANDLE_BITS-1:0]   hit_handle;
  logic [HANDLE_BITS-1:0]   result_handle;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign cmd.cmp   = in_xfer;
  assign cmd.exec  = fire;
  assign cmd.func  = func_q;
  assign cmd.found = found;
  assign cmd.full  = (count_q == CntFull);

  // Chain of cells, each linked to both neighbours.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == TABLE_DEPTH - 1) ? i : i + 1;

    assign cell_valid[i] = (count_q > CntW'(i));

    spt_cell #(
      .POSITION_BITS(POSITION_BITS),
      .HANDLE_BITS  (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .key_i         (position_i),
      .new_pos_i     (pos_q),
      .new_handle_i  (hin_q),
      .valid_i       (cell_valid[i]),
      .left_after_i  ((i == 0) ? 1'b0 : cell_after[L]),
      .left_pos_i    (cell_pos[L]),
      .left_handle_i (cell_handle[L]),
      .right_pos_i   (cell_pos[R]),
      .right_handle_i(cell_handle[R]),
      .after_o       (cell_after[i]),
      .hit_o         (cell_hit[i]),
      .at_max_o      (cell_max[i]),
      .at_zero_o     (cell_zero[i]),
      .pos_o         (cell_pos[i]),
      .handle_o      (cell_handle[i])
    );
  end

  // Combine the per-cell flags; at most one cell reports a hit.
  always_comb begin
    hit_handle = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      hit_handle = hit_handle | (cell_hit[k] ? cell_handle[k] : '0);
    end
  end

  assign found  = |cell_hit;
  assign sat_up = |cell_max;
  assign sat_dn = |cell_zero;

  // Only get and release report the handle found at the lower bound.
  assign result_handle = ((func_q == FN_RELEASE) || (func_q == FN_GET)) ? hit_handle : '0;

  // Controller: request capture, entry count and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      func_q       <= '0;
      pos_q        <= '0;
      hin_q        <= '0;
      handle_out_q <= '0;
      status_q     <= ST_OK;
    end else begin
      // The result is loaded when a request is applied and dropped once transferred.
      if (fire) begin
        out_valid_q  <= 1'b1;
        handle_out_q <= result_handle;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            func_q  <= func_i;
            pos_q   <= position_i;
            hin_q   <= handle_in_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_q <= S_IDLE;
            unique case (func_q)
              FN_INSERT: begin
                if (found) begin
                  status_q <= ST_PRESENT;
                end else if (cmd.full) begin
                  status_q <= ST_FULL;
                end else begin
                  status_q <= ST_OK;
                  count_q  <= count_q + CntW'(1);
                end
              end
              FN_ERASE: begin
                if (found) begin
                  status_q <= ST_OK;
                  count_q  <= count_q - CntW'(1);
                end else begin
                  status_q <= ST_NOT_FOUND;
                end
              end
              FN_RELEASE, FN_GET: status_q <= found ? ST_OK : ST_NOT_FOUND;
              FN_SHIFT_UP: status_q <= sat_up ? ST_SATURATED : ST_OK;
              FN_SHIFT_DN: status_q <= sat_dn ? ST_SATURATED : ST_OK;
              default:     status_q <= ST_NOT_FOUND;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = handle_out_q;
  assign status_o     = status_q;

`ifndef ASSERT_OFF
  // Only one cell can sit at the lower bound.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(cell_hit))
    else $error("more than one cell reports a hit");

  // The entry count changes only when a request is applied.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q))
    else $error("entry count changed without a request");

  // The entry count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (count_q <= CntFull))
    else $error("entry count beyond table depth");

  // Applying a request always presents a result.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (state_q == S_IDLE))
    else $error("applied request gave no result");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_position_table_unit: drives requests with random gaps,
// stalls the result side at random and checks every result against a predictor of the table.
// Depends on spt_pkg and the RTL of the block.
module tb;
  import spt_pkg::*;

  localparam int Depth = DefTableDepth;
  localparam int PosW  = DefPositionBits;
  localparam int HndW  = DefHandleBits;

  // Operation codes that the block does not define.
  localparam logic [FuncW-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FuncW-1:0] FN_RSVD7 = 3'd7;

  typedef struct packed {
    logic [HndW-1:0] handle;
    status_e         status;
  } lookup_result_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [FuncW-1:0] func_i     = '0;
  logic [PosW-1:0] position_i  = '0;
  logic [HndW-1:0] handle_in_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [HndW-1:0] handle_out_o;
  logic [StatusW-1:0] status_o;

  // Predicted table contents, updated at each input transfer.
  logic [PosW-1:0] tbl_pos [Depth];
  logic [HndW-1:0] tbl_hnd [Depth];
  int              tbl_count = 0;

  lookup_result_t  expected_q [$];
  int              fail_count = 0;
  bit              no_idle    = 1'b0;

  sorted_position_table_unit #(
    .TABLE_DEPTH  (Depth),
    .POSITION_BITS(PosW),
    .HANDLE_BITS  (HndW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .handle_in_i (handle_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .handle_out_o(handle_out_o),
    .status_o    (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Applies one request to the predicted table and returns the result it gives.
  function automatic lookup_result_t predict_request(logic [FuncW-1:0] fn, logic [PosW-1:0] pos,
                                                     logic [HndW-1:0] hnd);
    lookup_result_t res;
    int lb;
    bit hit;
    res.handle = '0;
    res.status = ST_OK;
    // Lower bound: first entry whose position is not below the key.
    lb = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_pos[i] >= pos) begin
        lb = i;
        break;
      end
    end
    hit = (lb < tbl_count) && (tbl_pos[lb] == pos);
    case (fn)
      FN_INSERT: begin
        if (hit) begin
          res.status = ST_PRESENT;
        end else if (tbl_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          for (int i = tbl_count; i > lb; i--) begin
            tbl_pos[i] = tbl_pos[i-1];
            tbl_hnd[i] = tbl_hnd[i-1];
          end
          tbl_pos[lb] = pos;
          tbl_hnd[lb] = hnd;
          tbl_count++;
        end
      end
      FN_ERASE: begin
        if (hit) begin
          for (int i = lb; i + 1 < tbl_count; i++) begin
            tbl_pos[i] = tbl_pos[i+1];
            tbl_hnd[i] = tbl_hnd[i+1];
          end
          tbl_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FN_RELEASE, FN_GET: begin
        if (hit) begin
          res.handle = tbl_hnd[lb];
          if (fn == FN_RELEASE) tbl_hnd[lb] = '0;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      FN_SHIFT_UP: begin
        for (int i = lb; i < tbl_count; i++) begin
          if (tbl_pos[i] == '1) res.status = ST_SATURATED;
          else tbl_pos[i] = tbl_pos[i] + 1'b1;
        end
      end
      FN_SHIFT_DN: begin
        for (int i = lb; i < tbl_count; i++) begin
          if (tbl_pos[i] == '0) res.status = ST_SATURATED;
          else tbl_pos[i] = tbl_pos[i] - 1'b1;
        end
      end
      default: begin
        res.status = ST_NOT_FOUND;
      end
    endcase
    return res;
  endfunction

  // Sends one request and records its expected result once the transfer happens.
  task automatic send_request(logic [FuncW-1:0] fn, logic [PosW-1:0] pos, logic [HndW-1:0] hnd);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    position_i  <= pos;
    handle_in_i <= hnd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_request(fn, pos, hnd));
  endtask

  // Position biased towards stored entries, their neighbours and the extremes.
  function automatic logic [PosW-1:0] pick_position();
    int r;
    logic [PosW-1:0] p;
    r = $urandom_range(0, 99);
    if (tbl_count > 0 && r < 50) begin
      p = tbl_pos[$urandom_range(0, tbl_count - 1)];
      if (r < 10) p = p + 1'b1;
    end else if (r < 70) begin
      p = PosW'($urandom_range(0, 255));
    end else if (r < 80) begin
      p = '1 - PosW'($urandom_range(0, 3));
    end else if (r < 85) begin
      p = PosW'($urandom_range(0, 3));
    end else begin
      p = PosW'($urandom);
    end
    return p;
  endfunction

  function automatic logic [HndW-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return HndW'($urandom);
  endfunction

  function automatic logic [FuncW-1:0] pick_func(int insert_pct);
    int r;
    if ($urandom_range(0, 99) < insert_pct) return FN_INSERT;
    r = $urandom_range(0, 99);
    if (r < 25) return FN_ERASE;
    if (r < 42) return FN_RELEASE;
    if (r < 70) return FN_GET;
    if (r < 82) return FN_SHIFT_UP;
    if (r < 94) return FN_SHIFT_DN;
    if (r < 97) return FN_RSVD6;
    return FN_RSVD7;
  endfunction

  // Every operation but insert on an empty table, including both undefined codes.
  task automatic test_empty_table();
    send_request(FN_GET, 16'h1234, 16'h0000);
    send_request(FN_ERASE, 16'hffff, 16'h0000);
    send_request(FN_RELEASE, 16'h0000, 16'hffff);
    send_request(FN_SHIFT_UP, 16'h0000, 16'h0000);
    send_request(FN_SHIFT_DN, 16'hffff, 16'h0000);
    send_request(FN_RSVD6, 16'hffff, 16'hffff);
    send_request(FN_RSVD7, 16'h5555, 16'haaaa);
  endtask

  // Extremes of position and handle, duplicates, empty slots and saturating shifts.
  task automatic test_special_cases();
    send_request(FN_INSERT, 16'h0000, 16'hffff);
    send_request(FN_INSERT, 16'hffff, 16'h0001);
    send_request(FN_INSERT, 16'h8000, 16'h0000);
    send_request(FN_INSERT, 16'h0000, 16'h5555);
    send_request(FN_GET, 16'h8000, 16'h0000);
    send_request(FN_RELEASE, 16'h0000, 16'h0000);
    send_request(FN_RELEASE, 16'h0000, 16'h0000);
    send_request(FN_GET, 16'h0000, 16'h0000);
    send_request(FN_GET, 16'h7fff, 16'h0000);
    send_request(FN_INSERT, 16'hfffe, 16'haaaa);
    // The entry at the top stays put and its neighbour lands on the same position.
    send_request(FN_SHIFT_UP, 16'h8000, 16'h0000);
    send_request(FN_GET, 16'hffff, 16'h0000);
    send_request(FN_INSERT, 16'hffff, 16'h0002);
    send_request(FN_SHIFT_DN, 16'h0000, 16'h0000);
    send_request(FN_ERASE, 16'h0000, 16'h0000);
    send_request(FN_ERASE, 16'h0000, 16'h0000);
    send_request(FN_ERASE, 16'hffff, 16'h0000);
    send_request(FN_GET, 16'hffff, 16'h0000);
  endtask

  // Fills the table back to back, then pushes against the full condition.
  task automatic test_table_full();
    int guard;
    guard = 0;
    no_idle = 1'b1;
    while (tbl_count < Depth && guard < 400) begin
      send_request(FN_INSERT, PosW'($urandom), pick_handle());
      guard++;
    end
    no_idle = 1'b0;
    repeat (4) send_request(FN_INSERT, PosW'($urandom), pick_handle());
    send_request(FN_INSERT, tbl_pos[$urandom_range(0, Depth - 1)], pick_handle());
    send_request(FN_INSERT, '0, pick_handle());
    send_request(FN_INSERT, '1, pick_handle());
    repeat (6) send_request(FN_GET, pick_position(), '0);
    repeat (20) begin
      if (tbl_count > 0)
        send_request(FN_ERASE, tbl_pos[$urandom_range(0, tbl_count - 1)], '0);
    end
  endtask

  // Mixed traffic in phases that grow, churn and drain the table.
  task automatic test_random_mix();
    int insert_pct [5] = '{60, 35, 40, 15, 55};
    for (int ph = 0; ph < 5; ph++) begin
      no_idle = (ph == 2);
      repeat (145) send_request(pick_func(insert_pct[ph]), pick_position(), pick_handle());
    end
    no_idle = 1'b0;
  endtask

  // Result side: random stall bursts, and each transfer checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    lookup_result_t want;
    int stall_left;
    int open_left;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (handle_out_o !== want.handle) begin
            $error("handle_out: expected %h, actual %h", want.handle, handle_out_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
        end
      end
      if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (open_left > 0) begin
          open_left--;
        end else begin
          stall_left = pick_gap();
          open_left  = $urandom_range(0, 6);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_special_cases();
    test_table_full();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #1000000;
    $error("timed out with %0d results outstanding", expected_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule
